@@ design/maps_pkg.sv @@
// shared types and constants of the active profile selector
`default_nettype none

package maps_pkg;

    // width of a profile number and of the running mask word
    localparam int PROF_W = 4;
    localparam int MASK_W = 16;
    localparam int OP_W   = 3;

    // event codes
    localparam logic [OP_W-1:0] OP_START  = 3'd0;
    localparam logic [OP_W-1:0] OP_STOP   = 3'd1;
    localparam logic [OP_W-1:0] OP_RESCAN = 3'd2;
    localparam logic [OP_W-1:0] OP_ADD    = 3'd3;
    localparam logic [OP_W-1:0] OP_REMOVE = 3'd4;

    // what every history cell does this cycle
    typedef enum logic [1:0] {
        CA_HOLD   = 2'd0,
        CA_INSERT = 2'd1,
        CA_DELETE = 2'd2
    } t_cell_act;

    // command broadcast to the history chain
    typedef struct packed {
        t_cell_act           act;
        logic [PROF_W-1:0]   key;
    } t_cell_cmd;

endpackage

`default_nettype wire

@@ design/maps_cell.sv @@
// one history cell: holds one entry, matches it, shifts with its neighbors
`default_nettype none

module maps_cell #(
    parameter int IDX           = 0,
    parameter int HISTORY_DEPTH = 10,
    parameter int NUM_PROFILES  = 16
) (
    input  wire                                 i_clk,
    input  wire maps_pkg::t_cell_cmd            i_cmd,
    input  wire [$clog2(HISTORY_DEPTH+1)-1:0]   i_len,
    input  wire [NUM_PROFILES-1:0]              i_live,
    input  wire [maps_pkg::PROF_W-1:0]          i_prev_entry,
    input  wire [maps_pkg::PROF_W-1:0]          i_next_entry,
    input  wire                                 i_found,
    input  wire                                 i_live_seen,
    output logic [maps_pkg::PROF_W-1:0]         o_entry,
    output logic                                o_found,
    output logic                                o_live_seen,
    output logic [maps_pkg::PROF_W-1:0]         o_pick
);

    localparam int LW  = $clog2(HISTORY_DEPTH + 1);
    localparam int PIW = $clog2(NUM_PROFILES);
    localparam int PW  = maps_pkg::PROF_W;

    logic [PW-1:0] r_entry;
    logic [PW-1:0] n_entry;
    logic          w_valid;
    logic          w_match;
    logic          w_live;

    // occupancy, key match and liveness of the held entry
    always_comb begin
        w_valid = (LW'(IDX) < i_len);
        w_match = w_valid && (r_entry == i_cmd.key);
        w_live  = w_valid && ({28'd0, r_entry} < 32'(NUM_PROFILES))
                  && i_live[PIW'(r_entry)];
    end

    // chain outputs: match seen so far, first live entry
    always_comb begin
        o_entry     = r_entry;
        o_found     = i_found | w_match;
        o_live_seen = i_live_seen | w_live;
        o_pick      = (w_live && !i_live_seen) ? r_entry : '0;
    end

    // insert at front shifts down up to the match, delete closes the gap
    always_comb begin
        n_entry = r_entry;
        case (i_cmd.act)
            maps_pkg::CA_INSERT: begin
                if (!i_found && (LW'(IDX) <= i_len)) begin
                    n_entry = i_prev_entry;
                end
            end
            maps_pkg::CA_DELETE: begin
                if (i_found || w_match) begin
                    n_entry = i_next_entry;
                end
            end
            default: begin
                n_entry = r_entry;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

`default_nettype wire

@@ design/mru_active_profile_selector.sv @@
// top level: profile flags, display state, sequencer and the history cell chain
// start, add, remove and ignored events go through the exec state, then strobe o_done;
// stop of the displayed profile and rescan go on to the pick state, which ends the event
// when nothing is live, else the move state follows (fallback pick, then move to front).
// busy holds off the next word until the result cycle, so a new word is not taken
// before the last one is through.
// reset (synchronous, active low) clears flags, history count and display.
`default_nettype none

module mru_active_profile_selector #(
    parameter int NUM_PROFILES  = 16,
    parameter int HISTORY_DEPTH = 10
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          start,
    output logic                         busy,
    input  wire [maps_pkg::OP_W-1:0]     i_op,
    input  wire [maps_pkg::PROF_W-1:0]   i_profile_id,
    input  wire [maps_pkg::MASK_W-1:0]   i_running_mask,
    output logic                         o_done,
    output logic                         o_display_valid,
    output logic [maps_pkg::PROF_W-1:0]  o_display_profile,
    output logic                         o_display_changed,
    output logic [3:0]                   o_history_count
);

    localparam int LW  = $clog2(HISTORY_DEPTH + 1);
    localparam int PIW = $clog2(NUM_PROFILES);
    localparam int PW  = maps_pkg::PROF_W;
    localparam int MW  = maps_pkg::MASK_W;
    localparam int OW  = maps_pkg::OP_W;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EXEC = 4'b0010,
        S_PICK = 4'b0100,
        S_MOVE = 4'b1000
    } t_state;

    t_state              r_state, n_state;
    logic [OW-1:0]       r_op;
    logic [PW-1:0]       r_pid;
    logic [MW-1:0]       r_mask;
    logic [NUM_PROFILES-1:0] r_cfg, n_cfg;
    logic [NUM_PROFILES-1:0] r_run, n_run;
    logic [LW-1:0]       r_len, n_len;
    logic                r_shown_valid, n_shown_valid;
    logic [PW-1:0]       r_shown_prof, n_shown_prof;
    logic                r_old_valid;
    logic [PW-1:0]       r_old_prof;
    logic [PW-1:0]       r_pick, n_pick;
    logic                r_done, n_done;

    maps_pkg::t_cell_cmd w_cmd;
    logic [NUM_PROFILES-1:0] w_live;
    logic [NUM_PROFILES-1:0] w_run_load;
    logic [PW-1:0]       w_entry [HISTORY_DEPTH];
    logic [PW-1:0]       w_pick  [HISTORY_DEPTH];
    logic                w_found     [HISTORY_DEPTH+1];
    logic                w_live_seen [HISTORY_DEPTH+1];
    logic [PW-1:0]       w_hist_pick;
    logic                w_lo_any;
    logic [PIW-1:0]      w_lo_idx;
    logic                w_pok;
    logic [PIW-1:0]      w_pidx;
    logic [LW-1:0]       w_len_inc;
    logic                w_accept;

    assign w_accept = start && !busy;
    assign w_live   = r_cfg & r_run;
    assign w_found[0]     = 1'b0;
    assign w_live_seen[0] = 1'b0;

    // rescan load: only configured profiles with a mask bit run
    genvar gi;
    generate
        for (gi = 0; gi < NUM_PROFILES; gi++) begin : g_load
            if (gi < MW) begin : g_in
                assign w_run_load[gi] = r_cfg[gi] & r_mask[gi];
            end else begin : g_out
                assign w_run_load[gi] = 1'b0;
            end
        end
    endgenerate

    // history cell chain
    generate
        for (gi = 0; gi < HISTORY_DEPTH; gi++) begin : g_cell
            logic [PW-1:0] w_prev;
            logic [PW-1:0] w_next;
            if (gi == 0) begin : g_first
                assign w_prev = w_cmd.key;
            end else begin : g_mid
                assign w_prev = w_entry[gi-1];
            end
            if (gi == HISTORY_DEPTH - 1) begin : g_last
                assign w_next = w_entry[gi];
            end else begin : g_body
                assign w_next = w_entry[gi+1];
            end
            maps_cell #(
                .IDX           (gi),
                .HISTORY_DEPTH (HISTORY_DEPTH),
                .NUM_PROFILES  (NUM_PROFILES)
            ) u_cell (
                .i_clk        (i_clk),
                .i_cmd        (w_cmd),
                .i_len        (r_len),
                .i_live       (w_live),
                .i_prev_entry (w_prev),
                .i_next_entry (w_next),
                .i_found      (w_found[gi]),
                .i_live_seen  (w_live_seen[gi]),
                .o_entry      (w_entry[gi]),
                .o_found      (w_found[gi+1]),
                .o_live_seen  (w_live_seen[gi+1]),
                .o_pick       (w_pick[gi])
            );
        end
    endgenerate

    // first live history entry: only one cell drives a nonzero pick
    always_comb begin
        w_hist_pick = '0;
        for (int i = 0; i < HISTORY_DEPTH; i++) begin
            w_hist_pick = w_hist_pick | w_pick[i];
        end
    end

    // lowest-numbered live profile
    always_comb begin
        w_lo_any = 1'b0;
        w_lo_idx = '0;
        for (int i = NUM_PROFILES - 1; i >= 0; i--) begin
            if (w_live[i]) begin
                w_lo_any = 1'b1;
                w_lo_idx = PIW'(i);
            end
        end
    end

    assign w_pok     = ({28'd0, r_pid} < 32'(NUM_PROFILES));
    assign w_pidx    = PIW'(r_pid);
    assign w_len_inc = (r_len < LW'(HISTORY_DEPTH)) ? (r_len + LW'(1)) : r_len;

    // event sequencer
    always_comb begin
        n_state       = r_state;
        n_cfg         = r_cfg;
        n_run         = r_run;
        n_len         = r_len;
        n_shown_valid = r_shown_valid;
        n_shown_prof  = r_shown_prof;
        n_pick        = r_pick;
        n_done        = 1'b0;
        w_cmd.act     = maps_pkg::CA_HOLD;
        w_cmd.key     = r_pid;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_IDLE;
                n_done  = 1'b1;
                case (r_op)
                    maps_pkg::OP_START: begin
                        if (w_pok && r_cfg[w_pidx] && !r_run[w_pidx]) begin
                            n_run[w_pidx] = 1'b1;
                            n_shown_valid = 1'b1;
                            n_shown_prof  = r_pid;
                            w_cmd.act     = maps_pkg::CA_INSERT;
                            n_len = w_found[HISTORY_DEPTH] ? r_len : w_len_inc;
                        end
                    end
                    maps_pkg::OP_STOP: begin
                        if (w_pok && r_cfg[w_pidx] && r_run[w_pidx]) begin
                            n_run[w_pidx] = 1'b0;
                            if (r_shown_valid && (r_shown_prof == r_pid)) begin
                                n_state = S_PICK;
                                n_done  = 1'b0;
                            end
                        end
                    end
                    maps_pkg::OP_RESCAN: begin
                        n_run   = w_run_load;
                        n_state = S_PICK;
                        n_done  = 1'b0;
                    end
                    maps_pkg::OP_ADD: begin
                        if (w_pok) begin
                            n_cfg[w_pidx] = 1'b1;
                            n_run[w_pidx] = r_mask[r_pid];
                        end
                    end
                    maps_pkg::OP_REMOVE: begin
                        if (w_pok && r_cfg[w_pidx]) begin
                            n_cfg[w_pidx] = 1'b0;
                            n_run[w_pidx] = 1'b0;
                            if (r_shown_valid && (r_shown_prof == r_pid)) begin
                                n_shown_valid = 1'b0;
                                n_shown_prof  = '0;
                            end
                            w_cmd.act = maps_pkg::CA_DELETE;
                            n_len = w_found[HISTORY_DEPTH] ? (r_len - LW'(1)) : r_len;
                        end
                    end
                    default: begin
                        n_done = 1'b1;
                    end
                endcase
            end
            S_PICK: begin
                // history first, then lowest number, else nothing shown
                if (w_live_seen[HISTORY_DEPTH] || w_lo_any) begin
                    n_pick        = w_live_seen[HISTORY_DEPTH] ? w_hist_pick
                                                               : PW'(w_lo_idx);
                    n_shown_valid = 1'b1;
                    n_shown_prof  = n_pick;
                    n_state       = S_MOVE;
                end else begin
                    n_shown_valid = 1'b0;
                    n_shown_prof  = '0;
                    n_len         = '0;
                    n_state       = S_IDLE;
                    n_done        = 1'b1;
                end
            end
            S_MOVE: begin
                w_cmd.act = maps_pkg::CA_INSERT;
                w_cmd.key = r_pick;
                n_len     = w_found[HISTORY_DEPTH] ? r_len : w_len_inc;
                n_state   = S_IDLE;
                n_done    = 1'b1;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_cfg         <= '0;
            r_run         <= '0;
            r_len         <= '0;
            r_shown_valid <= 1'b0;
            r_shown_prof  <= '0;
            r_done        <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_cfg         <= n_cfg;
            r_run         <= n_run;
            r_len         <= n_len;
            r_shown_valid <= n_shown_valid;
            r_shown_prof  <= n_shown_prof;
            r_done        <= n_done;
        end
    end

    // command word and display snapshot taken at accept
    always_ff @(posedge i_clk) begin
        r_pick <= n_pick;
        if (w_accept) begin
            r_op        <= i_op;
            r_pid       <= i_profile_id;
            r_mask      <= i_running_mask;
            r_old_valid <= r_shown_valid;
            r_old_prof  <= r_shown_prof;
        end
    end

    // result ports
    assign busy              = (r_state != S_IDLE);
    assign o_done            = r_done;
    assign o_display_valid   = r_shown_valid;
    assign o_display_profile = r_shown_prof;
    assign o_display_changed = (r_old_valid != r_shown_valid)
                               || (r_shown_valid && (r_old_prof != r_shown_prof));
    assign o_history_count   = 4'(r_len);

endmodule

`default_nettype wire

@@ design/maps_checker.sv @@
// port-level checks of the active profile selector and their bind
`default_nettype none

module maps_checker #(
    parameter int HISTORY_DEPTH = 10
) (
    input wire       i_clk,
    input wire       i_rst_n,
    input wire       start,
    input wire       busy,
    input wire       o_done,
    input wire       o_display_valid,
    input wire [3:0] o_display_profile,
    input wire [3:0] o_history_count
);

    // an accepted word keeps the block busy for the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after accept");

    // no result in the cycle right after accept
    a_no_early_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> !o_done)
        else $error("result too early");

    // every result follows a busy cycle
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(busy))
        else $error("result without work");

    // a blank display reports profile zero
    a_blank_profile: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_display_valid) |-> (o_display_profile == 4'd0))
        else $error("profile set while display blank");

    // a shown profile implies a nonempty history, and the history stays within depth
    a_history_holds_shown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> ((32'(o_history_count) <= HISTORY_DEPTH)
                    && (!o_display_valid || (o_history_count != 4'd0))))
        else $error("history count inconsistent with display");

endmodule

bind mru_active_profile_selector maps_checker #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
) u_maps_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .start             (start),
    .busy              (busy),
    .o_done            (o_done),
    .o_display_valid   (o_display_valid),
    .o_display_profile (o_display_profile),
    .o_history_count   (o_history_count)
);

`default_nettype wire

@@ tb/sv/profile_display_checker.sv @@
// checker for the active profile selector: predicts each display word and compares it
`timescale 1ns / 100ps

module profile_display_checker #(
    parameter int NPROF  = 16,
    parameter int HDEPTH = 10
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_start,
    input  wire                           i_busy,
    input  wire [maps_pkg::OP_W-1:0]      i_op,
    input  wire [maps_pkg::PROF_W-1:0]    i_profile_id,
    input  wire [maps_pkg::MASK_W-1:0]    i_running_mask,
    input  wire                           i_done,
    input  wire                           i_display_valid,
    input  wire [maps_pkg::PROF_W-1:0]    i_display_profile,
    input  wire                           i_display_changed,
    input  wire [3:0]                     i_history_count,
    output int                            o_fail_count,
    output int                            o_pending
);

    localparam int PROF_W = maps_pkg::PROF_W;
    localparam int MASK_W = maps_pkg::MASK_W;
    localparam int OP_W   = maps_pkg::OP_W;

    // one display word as the block reports it
    typedef struct packed {
        logic              shown;
        logic [PROF_W-1:0] prof;
        logic              changed;
        logic [3:0]        hist_cnt;
    } t_disp_word;

    // shadow of the profile table, history and display
    logic [NPROF-1:0]  prof_cfg;
    logic [NPROF-1:0]  prof_run;
    logic [PROF_W-1:0] hist [HDEPTH];
    int                hist_len;
    logic              shown_vld;
    logic [PROF_W-1:0] shown_id;

    // display words still owed by the block, oldest first
    t_disp_word pending_displays [$];

    function automatic logic is_live(int p);
        return prof_cfg[p] && prof_run[p];
    endfunction

    // move a profile to the front of the history, dropping the oldest when full
    function automatic void promote(logic [PROF_W-1:0] p);
        int pos;
        bit found;
        pos = hist_len;
        found = 0;
        for (int i = 0; i < hist_len; i++) begin
            if (!found && hist[i] == p) begin
                pos = i;
                found = 1;
            end
        end
        if (!found) begin
            if (hist_len < HDEPTH) hist_len++;
            pos = hist_len - 1;
        end
        for (int i = pos; i > 0; i--) hist[i] = hist[i-1];
        hist[0] = p;
    endfunction

    // fallback: first live profile in history, else lowest live, else nothing
    function automatic void choose_display(bit has_skip, logic [PROF_W-1:0] skip);
        bit                found;
        logic [PROF_W-1:0] pick;
        found = 0;
        pick = '0;
        for (int i = 0; i < hist_len; i++) begin
            if (!found && !(has_skip && hist[i] == skip) && is_live(hist[i])) begin
                found = 1;
                pick = hist[i];
            end
        end
        for (int i = 0; i < NPROF; i++) begin
            if (!found && !(has_skip && i == skip) && is_live(i)) begin
                found = 1;
                pick = PROF_W'(i);
            end
        end
        if (found) begin
            shown_vld = 1'b1;
            shown_id = pick;
            promote(pick);
        end else begin
            shown_vld = 1'b0;
            shown_id = '0;
            hist_len = 0;
        end
    endfunction

    // apply one event to the shadow state and return the word it should produce
    function automatic t_disp_word predict_display(logic [OP_W-1:0] op,
                                                   logic [PROF_W-1:0] pid,
                                                   logic [MASK_W-1:0] mask);
        t_disp_word        res;
        logic              was_vld;
        logic [PROF_W-1:0] was_id;
        int                keep;
        was_vld = shown_vld;
        was_id = shown_id;
        case (op)
            maps_pkg::OP_START: begin
                if (prof_cfg[pid] && !prof_run[pid]) begin
                    prof_run[pid] = 1'b1;
                    promote(pid);
                    shown_vld = 1'b1;
                    shown_id = pid;
                end
            end
            maps_pkg::OP_STOP: begin
                if (prof_cfg[pid] && prof_run[pid]) begin
                    prof_run[pid] = 1'b0;
                    if (shown_vld && shown_id == pid) choose_display(1'b1, pid);
                end
            end
            maps_pkg::OP_RESCAN: begin
                prof_run = prof_cfg & NPROF'(mask);
                choose_display(1'b0, '0);
            end
            maps_pkg::OP_ADD: begin
                prof_cfg[pid] = 1'b1;
                prof_run[pid] = mask[pid];
            end
            maps_pkg::OP_REMOVE: begin
                if (prof_cfg[pid]) begin
                    prof_cfg[pid] = 1'b0;
                    prof_run[pid] = 1'b0;
                    if (shown_vld && shown_id == pid) shown_vld = 1'b0;
                    // prune history of profiles that are no longer configured
                    keep = 0;
                    for (int i = 0; i < hist_len; i++) begin
                        if (prof_cfg[hist[i]]) begin
                            hist[keep] = hist[i];
                            keep++;
                        end
                    end
                    hist_len = keep;
                end
            end
            default: ;
        endcase
        if (!shown_vld) shown_id = '0;
        res.shown = shown_vld;
        res.prof = shown_id;
        res.changed = (was_vld != shown_vld) || (shown_vld && was_id != shown_id);
        res.hist_cnt = 4'(hist_len);
        return res;
    endfunction

    function automatic void check_field(string fname, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", fname, want, got);
            o_fail_count++;
        end
    endfunction

    // retire results first, then record the word accepted on this edge
    always @(posedge i_clk) begin
        t_disp_word want;
        if (!i_rst_n) begin
            prof_cfg = '0;
            prof_run = '0;
            foreach (hist[i]) hist[i] = '0;
            hist_len = 0;
            shown_vld = 1'b0;
            shown_id = '0;
            pending_displays.delete();
            o_fail_count = 0;
        end else begin
            if (i_done) begin
                if (pending_displays.size() == 0) begin
                    $error("display word with no event outstanding");
                    o_fail_count++;
                end else begin
                    want = pending_displays.pop_front();
                    check_field("display_valid", want.shown, i_display_valid);
                    check_field("display_profile", want.prof, i_display_profile);
                    check_field("display_changed", want.changed, i_display_changed);
                    check_field("history_count", want.hist_cnt, i_history_count);
                end
            end
            if (i_start && !i_busy) begin
                want = predict_display(i_op, i_profile_id, i_running_mask);
                pending_displays.insert(pending_displays.size(), want);
            end
        end
        o_pending = pending_displays.size();
    end

endmodule

@@ tb/sv/tb_top.sv @@
// testbench top: clock, reset, event stimulus, watchdog and verdict
`timescale 1ns / 100ps

module tb_top;

    localparam int NPROF      = 16;
    localparam int HDEPTH     = 10;
    localparam int RAND_WORDS = 900;
    localparam int STALL_MAX  = 1000;
    localparam int DRAIN_CYC  = 8;
    localparam int PROF_W     = maps_pkg::PROF_W;
    localparam int MASK_W     = maps_pkg::MASK_W;
    localparam int OP_W       = maps_pkg::OP_W;

    // event codes the block treats as no-ops
    localparam logic [OP_W-1:0] OP_SPARE_LO = maps_pkg::OP_REMOVE + 1'b1;
    localparam logic [OP_W-1:0] OP_SPARE_HI = '1;

    logic              i_clk;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    logic [OP_W-1:0]   i_op;
    logic [PROF_W-1:0] i_profile_id;
    logic [MASK_W-1:0] i_running_mask;
    logic              o_done;
    logic              o_display_valid;
    logic [PROF_W-1:0] o_display_profile;
    logic              o_display_changed;
    logic [3:0]        o_history_count;
    int                fail_count;
    int                pending;
    int                stall_cycles;
    bit                idle_on;

    // rough view of the flags, used only to aim events at live profiles
    logic [NPROF-1:0]  cfg_view;
    logic [NPROF-1:0]  run_view;
    logic [PROF_W-1:0] last_started;

    mru_active_profile_selector #(
        .NUM_PROFILES  (NPROF),
        .HISTORY_DEPTH (HDEPTH)
    ) dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_op              (i_op),
        .i_profile_id      (i_profile_id),
        .i_running_mask    (i_running_mask),
        .o_done            (o_done),
        .o_display_valid   (o_display_valid),
        .o_display_profile (o_display_profile),
        .o_display_changed (o_display_changed),
        .o_history_count   (o_history_count)
    );

    profile_display_checker #(
        .NPROF  (NPROF),
        .HDEPTH (HDEPTH)
    ) u_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_start           (start),
        .i_busy            (busy),
        .i_op              (i_op),
        .i_profile_id      (i_profile_id),
        .i_running_mask    (i_running_mask),
        .i_done            (o_done),
        .i_display_valid   (o_display_valid),
        .i_display_profile (o_display_profile),
        .i_display_changed (o_display_changed),
        .i_history_count   (o_history_count),
        .o_fail_count      (fail_count),
        .o_pending         (pending)
    );

    // 12 ns clock
    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // watchdog: cycles with neither an accepted word nor a result
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_MAX) begin
            $display("FAIL mru_active_profile_selector");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // random member of a set of profiles, any profile if the set is empty
    function automatic logic [PROF_W-1:0] pick_from(logic [NPROF-1:0] set);
        int n;
        int k;
        n = $countones(set);
        if (n == 0) return PROF_W'($urandom_range(NPROF - 1));
        k = $urandom_range(n - 1);
        for (int i = 0; i < NPROF; i++) begin
            if (set[i]) begin
                if (k == 0) return PROF_W'(i);
                k--;
            end
        end
        return '0;
    endfunction

    // present one event word, with optional idle cycles ahead of it
    task automatic send_word(logic [OP_W-1:0] op, logic [PROF_W-1:0] pid,
                             logic [MASK_W-1:0] mask);
        while (idle_on && $urandom_range(99) < 36) begin
            @(negedge i_clk);
            start = 1'b0;
        end
        @(negedge i_clk);
        start = 1'b1;
        i_op = op;
        i_profile_id = pid;
        i_running_mask = mask;
        do @(posedge i_clk); while (busy);
        // track flags for stimulus aiming
        case (op)
            maps_pkg::OP_START: begin
                if (cfg_view[pid] && !run_view[pid]) begin
                    run_view[pid] = 1'b1;
                    last_started = pid;
                end
            end
            maps_pkg::OP_STOP:   run_view[pid] = 1'b0;
            maps_pkg::OP_RESCAN: run_view = cfg_view & NPROF'(mask);
            maps_pkg::OP_ADD: begin
                cfg_view[pid] = 1'b1;
                run_view[pid] = mask[pid];
            end
            maps_pkg::OP_REMOVE: begin
                cfg_view[pid] = 1'b0;
                run_view[pid] = 1'b0;
            end
            default: ;
        endcase
    endtask

    function automatic logic [OP_W-1:0] OP_OP_SPARE_PICK();
        return OP_W'($urandom_range(OP_SPARE_HI, OP_SPARE_LO));
    endfunction

    // one random event, mostly aimed at profiles where it takes effect
    task automatic send_random_word();
        int                r;
        logic [PROF_W-1:0] pid;
        logic [MASK_W-1:0] mask;
        r = $urandom_range(99);
        mask = MASK_W'($urandom);
        pid = PROF_W'($urandom_range(NPROF - 1));
        if (r < 38) begin
            if ($urandom_range(3) != 0) pid = pick_from(cfg_view & ~run_view);
            send_word(maps_pkg::OP_START, pid, mask);
        end else if (r < 62) begin
            if ($urandom_range(99) < 40) pid = last_started;
            else if ($urandom_range(3) != 0) pid = pick_from(cfg_view & run_view);
            send_word(maps_pkg::OP_STOP, pid, mask);
        end else if (r < 77) begin
            if ($urandom_range(99) < 60) pid = pick_from(~cfg_view);
            mask[pid] = ($urandom_range(99) < 70);
            send_word(maps_pkg::OP_ADD, pid, mask);
        end else if (r < 86) begin
            send_word(maps_pkg::OP_REMOVE, pid, mask);
        end else if (r < 95) begin
            case ($urandom_range(5))
                0: mask = '0;
                1: mask = '1;
                default: ;
            endcase
            send_word(maps_pkg::OP_RESCAN, pid, mask);
        end else begin
            send_word(OP_OP_SPARE_PICK(), pid, mask);
        end
    endtask

    initial begin
        start = 1'b0;
        i_op = maps_pkg::OP_START;
        i_profile_id = '0;
        i_running_mask = '0;
        i_rst_n = 1'b0;
        idle_on = 1'b1;
        cfg_view = '0;
        run_view = '0;
        last_started = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: ignored events on an empty table
        send_word(OP_SPARE_HI, 4'd0, 16'h0000);
        send_word(maps_pkg::OP_START, 4'd3, 16'hFFFF);
        send_word(maps_pkg::OP_STOP, 4'd3, 16'hFFFF);
        send_word(maps_pkg::OP_REMOVE, 4'd3, 16'h0000);
        // build a small table, extremes of the profile number
        send_word(maps_pkg::OP_ADD, 4'd0, 16'h0000);
        send_word(maps_pkg::OP_ADD, 4'd15, 16'h8000);
        send_word(maps_pkg::OP_ADD, 4'd5, 16'hFFDF);
        send_word(maps_pkg::OP_START, 4'd0, 16'h0000);
        send_word(maps_pkg::OP_START, 4'd15, 16'h0000);
        send_word(maps_pkg::OP_RESCAN, 4'd9, 16'hFFFF);
        // stops of two running profiles, neither of them the shown one
        send_word(maps_pkg::OP_STOP, 4'd5, 16'h0000);
        send_word(maps_pkg::OP_STOP, 4'd0, 16'h0000);
        // add of a configured profile reloads only its running flag
        send_word(maps_pkg::OP_ADD, 4'd15, 16'h0000);
        send_word(maps_pkg::OP_STOP, 4'd15, 16'hFFFF);
        // rescan with nothing running clears the history
        send_word(maps_pkg::OP_RESCAN, 4'd0, 16'h0000);
        send_word(maps_pkg::OP_START, 4'd5, 16'h0000);
        send_word(maps_pkg::OP_START, 4'd0, 16'h0000);
        // remove of the shown profile, then spare codes
        send_word(maps_pkg::OP_REMOVE, 4'd0, 16'hFFFF);
        send_word(OP_SPARE_LO, 4'd15, 16'hFFFF);
        send_word(OP_SPARE_LO + 1'b1, 4'd7, 16'h5A5A);
        send_word(maps_pkg::OP_REMOVE, 4'd15, 16'h0000);
        send_word(maps_pkg::OP_RESCAN, 4'd15, 16'hFFFF);

        // random events, with a stretch of back-to-back words
        for (int n = 0; n < RAND_WORDS; n++) begin
            idle_on = !(n >= 300 && n < 450);
            send_random_word();
        end

        @(negedge i_clk);
        start = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("PASS mru_active_profile_selector");
        end else begin
            $display("FAIL mru_active_profile_selector");
        end
        $finish;
    end

endmodule
